@@ design/fts_pkg.sv @@
// Shared types and constants for the failover target selector.
// No dependencies; imported by every module of the block.
`default_nettype none

package fts_pkg;

   localparam int MAX_TARGETS_DEF = 8;
   localparam int CNT_W           = 4;
   localparam int IDX_W           = 3;
   localparam int TIME_W          = 32;
   localparam int CSR_IDX_W       = 2;

   localparam logic [TIME_W-1:0]    HOLDOFF_RESET    = 32'd600;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF      = 2'd1;

   typedef enum logic [1:0] {
      OP_SEL_EMPTY = 2'd0,
      OP_SEL_SCAN  = 2'd1,
      OP_MARK_HIT  = 2'd2,
      OP_MARK_MISS = 2'd3
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  tidx;
      logic [TIME_W-1:0] now;
      logic              nonempty;
   } item_type;

endpackage

`default_nettype wire

@@ design/fts_front.sv @@
// Front end: accepts request transactions, classifies them against the
// target count and holds them in a two-entry queue. Depends on fts_pkg.
`default_nettype none

module fts_front
   import fts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_func,
   input  wire logic [IDX_W-1:0]  req_target_index,
   input  wire logic [TIME_W-1:0] req_now_time,
   input  wire logic [CNT_W-1:0]  target_count,
   output logic                   q_valid,
   output item_type               q_item,
   input  wire logic              q_pop
);

   item_type   entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   item_type   cls;

   assign req_stall = fill_ff[1];
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      cls.tidx     = req_target_index;
      cls.now      = req_now_time;
      cls.nonempty = (target_count != '0);
      if (req_func) begin
         cls.op = ({1'b0, req_target_index} < target_count) ? OP_MARK_HIT : OP_MARK_MISS;
      end else begin
         cls.op = (target_count != '0) ? OP_SEL_SCAN : OP_SEL_EMPTY;
      end
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({push, q_pop})
         2'b10:   fill_in = fill_ff + 2'd1;
         2'b01:   fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

@@ design/fts_back.sv @@
// Back end: deadline memory, one-entry-per-cycle select scan, mark-dead
// update and the response register. Depends on fts_pkg.
`default_nettype none

module fts_back
   import fts_pkg::*;
#(
   parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  item_type               q_item,
   output logic                   q_pop,
   input  wire logic              clear_all,
   input  wire logic [CNT_W-1:0]  target_count,
   input  wire logic [TIME_W-1:0] holdoff,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [IDX_W-1:0]       rsp_selected_index,
   output logic                   rsp_list_nonempty,
   output logic                   rsp_all_dead,
   output logic                   rsp_target_found
);

   localparam int ADDR_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]  best_idx_ff, best_idx_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [TIME_W-1:0] now_ff, now_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_sel_ff, rsp_sel_in;
   logic              rsp_nonempty_ff, rsp_nonempty_in;
   logic              rsp_all_dead_ff, rsp_all_dead_in;
   logic              rsp_found_ff, rsp_found_in;

   logic [TIME_W-1:0]    mem [MAX_TARGETS];
   logic [MAX_TARGETS-1:0] live_ff;
   logic [TIME_W-1:0]    rd_data_ff;
   logic                 rd_live_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 wr_en;
   logic [TIME_W-1:0]    wr_data;
   logic [TIME_W:0]      sum;

   logic [TIME_W-1:0] cur_val;
   logic [CNT_W-1:0]  last_idx;
   logic [CNT_W-1:0]  new_best_idx;
   logic              take_new;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_selected_index = rsp_sel_ff;
   assign rsp_list_nonempty  = rsp_nonempty_ff;
   assign rsp_all_dead       = rsp_all_dead_ff;
   assign rsp_target_found   = rsp_found_ff;

   assign q_pop    = (state_ff == ST_IDLE) && q_valid && (!rsp_valid_ff || !rsp_stall);
   assign sum      = {1'b0, q_item.now} + {1'b0, holdoff};
   assign wr_data  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
   assign wr_addr  = ADDR_W'(q_item.tidx);
   assign wr_en    = q_pop && (q_item.op == OP_MARK_HIT);
   assign rd_addr  = (state_ff == ST_SCAN) ? ADDR_W'(cmp_idx_ff + 4'd1) : '0;
   assign cur_val  = rd_live_ff ? rd_data_ff : '0;
   assign last_idx = target_count - 4'd1;
   assign take_new = (cmp_idx_ff == '0) || (cur_val < best_ff);
   assign new_best_idx = take_new ? cmp_idx_ff : best_idx_ff;

   always_comb begin
      state_in        = state_ff;
      cmp_idx_in      = cmp_idx_ff;
      best_idx_in     = best_idx_ff;
      best_in         = best_ff;
      now_in          = now_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_sel_in      = rsp_sel_ff;
      rsp_nonempty_in = rsp_nonempty_ff;
      rsp_all_dead_in = rsp_all_dead_ff;
      rsp_found_in    = rsp_found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               rsp_sel_in      = '0;
               rsp_nonempty_in = q_item.nonempty;
               rsp_all_dead_in = 1'b0;
               rsp_found_in    = 1'b0;
               unique case (q_item.op)
                  OP_SEL_EMPTY: rsp_valid_in = 1'b1;
                  OP_MARK_HIT: begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = 1'b1;
                  end
                  OP_MARK_MISS: rsp_valid_in = 1'b1;
                  OP_SEL_SCAN: begin
                     state_in   = ST_SCAN;
                     cmp_idx_in = '0;
                     now_in     = q_item.now;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            best_idx_in = new_best_idx;
            best_in     = take_new ? cur_val : best_ff;
            cmp_idx_in  = cmp_idx_ff + 4'd1;
            priority if (cur_val <= now_ff) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_sel_in   = IDX_W'(cmp_idx_ff);
            end else if (cmp_idx_ff == last_idx) begin
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_sel_in      = IDX_W'(new_best_idx);
               rsp_all_dead_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff      <= cmp_idx_in;
      best_idx_ff     <= best_idx_in;
      best_ff         <= best_in;
      now_ff          <= now_in;
      rsp_sel_ff      <= rsp_sel_in;
      rsp_nonempty_ff <= rsp_nonempty_in;
      rsp_all_dead_ff <= rsp_all_dead_in;
      rsp_found_ff    <= rsp_found_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         live_ff <= '0;
      end else if (wr_en) begin
         live_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_live_ff <= live_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/failover_target_selector.sv @@
// Mark-dead and empty-list select go from the front queue to the response register;
// select with targets also scans 1..target_count entries, with the deadline memory
// read one entry per cycle in the back end.
// Throughput: one transaction in flight in the back end; two more queue up front.
// Reset: synchronous, clears queue, control state and all deadlines to live,
// target_count to 0 and holdoff_ticks to 600.
`default_nettype none

module failover_target_selector
   import fts_pkg::*;
#(
   parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_func,
   input  wire logic [IDX_W-1:0]     req_target_index,
   input  wire logic [TIME_W-1:0]    req_now_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [IDX_W-1:0]          rsp_selected_index,
   output logic                      rsp_list_nonempty,
   output logic                      rsp_all_dead,
   output logic                      rsp_target_found,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_wdata
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] holdoff_ff, holdoff_in;
   logic [CNT_W-1:0]  count_wr;
   logic              csr_wr;
   logic              clear_all;
   logic              q_valid;
   logic              q_pop;
   item_type          q_item;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign clear_all = csr_wr && (csr_index == CSR_TARGET_COUNT);
   assign count_wr  = (32'(csr_wdata[CNT_W-1:0]) > MAX_TARGETS) ?
                      CNT_W'(MAX_TARGETS) : csr_wdata[CNT_W-1:0];
   assign count_in   = clear_all ? count_wr : count_ff;
   assign holdoff_in = (csr_wr && (csr_index == CSR_HOLDOFF)) ? csr_wdata : holdoff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         holdoff_ff <= HOLDOFF_RESET;
      end else begin
         count_ff   <= count_in;
         holdoff_ff <= holdoff_in;
      end
   end

   fts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_target_index (req_target_index),
      .req_now_time     (req_now_time),
      .target_count     (count_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop)
   );

   fts_back #(
      .MAX_TARGETS (MAX_TARGETS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .clear_all          (clear_all),
      .target_count       (count_ff),
      .holdoff            (holdoff_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_selected_index (rsp_selected_index),
      .rsp_list_nonempty  (rsp_list_nonempty),
      .rsp_all_dead       (rsp_all_dead),
      .rsp_target_found   (rsp_target_found)
   );

endmodule

`default_nettype wire

@@ design/fts_checker.sv @@
// Port-level checker for the failover target selector and its bind.
// Depends on fts_pkg and the top level failover_target_selector.
`default_nettype none

module fts_checker
   import fts_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [IDX_W-1:0] rsp_selected_index,
   input wire logic             rsp_list_nonempty,
   input wire logic             rsp_all_dead,
   input wire logic             rsp_target_found
);

   a_dead_needs_list: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_dead |-> rsp_list_nonempty)
      else $error("all_dead without a target list");

   a_found_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target_found |->
         !rsp_all_dead && (rsp_selected_index == '0) && rsp_list_nonempty)
      else $error("mark-dead response carries select fields");

   a_empty_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_list_nonempty |->
         !rsp_all_dead && !rsp_target_found && (rsp_selected_index == '0))
      else $error("empty list response not all zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_selected_index) &&
         $stable(rsp_all_dead) && $stable(rsp_target_found) &&
         $stable(rsp_list_nonempty))
      else $error("stalled response changed");

endmodule

bind failover_target_selector fts_checker u_fts_checker (.*);

`default_nettype wire

@@ bench/fts_tb_pkg.sv @@
// Function codes and spare register indexes used by the failover selector bench.
// Depends on fts_pkg for the register index width.
package fts_tb_pkg;

   localparam logic FUNC_SELECT    = 1'b0;
   localparam logic FUNC_MARK_DEAD = 1'b1;

   localparam logic [fts_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [fts_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

endpackage

@@ bench/fts_checker.sv @@
// Checker for the failover target selector: tracks register writes, predicts each
// response from its own deadline table and compares it field by field.
// Depends on fts_pkg and fts_tb_pkg.
module fts_bench_checker
   import fts_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic                 req_func,
   input  wire logic [IDX_W-1:0]     req_target_index,
   input  wire logic [TIME_W-1:0]    req_now_time,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic [IDX_W-1:0]     rsp_selected_index,
   input  wire logic                 rsp_list_nonempty,
   input  wire logic                 rsp_all_dead,
   input  wire logic                 rsp_target_found,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIME_W-1:0]    csr_wdata,
   output int                        mismatches,
   output int                        outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import fts_tb_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] selected;
      logic             nonempty;
      logic             all_dead;
      logic             found;
   } failover_answer;

   logic [TIME_W-1:0] deadline [MAX_TARGETS_DEF];
   int unsigned       listed;
   logic [TIME_W-1:0] holdoff;
   failover_answer    pending_answers [$];

   function automatic void clear_deadlines();
      int i;
      for (i = 0; i < MAX_TARGETS_DEF; i++) deadline[i] = '0;
   endfunction

   function automatic failover_answer resolve_request(input logic f,
                                                      input logic [IDX_W-1:0] tidx,
                                                      input logic [TIME_W-1:0] now);
      failover_answer a;
      logic [TIME_W:0] sum;
      int i;
      int coldest;
      bit live;
      a = '0;
      a.nonempty = (listed != 0);
      if (f == FUNC_SELECT) begin
         if (listed != 0) begin
            coldest = 0;
            live = 1'b0;
            for (i = 0; i < listed; i++) begin
               if (!live) begin
                  if (deadline[i] <= now) begin
                     live = 1'b1;
                     a.selected = i[IDX_W-1:0];
                  end else if (deadline[i] < deadline[coldest]) begin
                     coldest = i;
                  end
               end
            end
            if (!live) begin
               a.selected = coldest[IDX_W-1:0];
               a.all_dead = 1'b1;
            end
         end
      end else if (tidx < listed) begin
         sum = {1'b0, now} + {1'b0, holdoff};
         deadline[tidx] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
         a.found = 1'b1;
      end
      return a;
   endfunction

   function automatic void check_field(input string name, input logic [TIME_W-1:0] want,
                                       input logic [TIME_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : monitor
      failover_answer got;
      failover_answer want;
      logic [CNT_W-1:0] cnt;
      if (reset) begin
         listed = 0;
         holdoff = HOLDOFF_RESET;
         clear_deadlines();
         pending_answers.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET_COUNT: begin
                  cnt = csr_wdata[CNT_W-1:0];
                  listed = (cnt > MAX_TARGETS_DEF) ? MAX_TARGETS_DEF : cnt;
                  clear_deadlines();
               end
               CSR_HOLDOFF: begin
                  holdoff = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_selected_index, rsp_list_nonempty, rsp_all_dead, rsp_target_found};
            if (pending_answers.size() == 0) begin
               mismatches++;
               $display("%0t: response expected none, actual %h", $time, got);
            end else begin
               want = pending_answers.pop_front();
               check_field("selected_index", TIME_W'(want.selected), TIME_W'(got.selected));
               check_field("list_nonempty", TIME_W'(want.nonempty), TIME_W'(got.nonempty));
               check_field("all_dead", TIME_W'(want.all_dead), TIME_W'(got.all_dead));
               check_field("target_found", TIME_W'(want.found), TIME_W'(got.found));
            end
         end
         if (req_valid && !req_stall)
            pending_answers.push_back(resolve_request(req_func, req_target_index,
                                                      req_now_time));
      end
      outstanding <= pending_answers.size();
   end

endmodule

@@ bench/tb_failover_target_selector.sv @@
// Top of the failover target selector bench: clock, reset, directed and random
// transactions, register writes and the verdict. Depends on fts_pkg, fts_tb_pkg,
// fts_bench_checker and the failover_target_selector RTL.
module tb_failover_target_selector;
   timeunit 1ns;
   timeprecision 1ps;
   import fts_pkg::*;
   import fts_tb_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_func = FUNC_SELECT;
   logic [IDX_W-1:0]     req_target_index = '0;
   logic [TIME_W-1:0]    req_now_time = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [IDX_W-1:0]     rsp_selected_index;
   logic                 rsp_list_nonempty;
   logic                 rsp_all_dead;
   logic                 rsp_target_found;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TARGET_COUNT;
   logic [TIME_W-1:0]    csr_wdata = '0;
   int                   mismatches;
   int                   outstanding;
   bit                   calm = 1'b0;
   int                   stall_left = 0;

   always #1 clock = ~clock;

   failover_target_selector u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_target_index   (req_target_index),
      .req_now_time       (req_now_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_selected_index (rsp_selected_index),
      .rsp_list_nonempty  (rsp_list_nonempty),
      .rsp_all_dead       (rsp_all_dead),
      .rsp_target_found   (rsp_target_found),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   fts_bench_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_target_index   (req_target_index),
      .req_now_time       (req_now_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_selected_index (rsp_selected_index),
      .rsp_list_nonempty  (rsp_list_nonempty),
      .rsp_all_dead       (rsp_all_dead),
      .rsp_target_found   (rsp_target_found),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatches         (mismatches),
      .outstanding        (outstanding)
   );

   always @(posedge clock) begin : responder
      int hold;
      if (rsp_valid && !rsp_stall) begin
         hold = calm ? 0 : $urandom_range(0, 7);
         stall_left <= hold;
         rsp_stall <= (hold != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   task automatic issue(input logic f, input logic [IDX_W-1:0] tidx,
                        input logic [TIME_W-1:0] now);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_target_index <= tidx;
      req_now_time <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid and wait until every transaction has been answered
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin : stimulus
      int phase;
      int k;
      int r;
      int unsigned count;
      int unsigned listed;
      int unsigned step;
      logic [TIME_W-1:0] tnow;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] hold_ticks;
      logic [IDX_W-1:0] idx;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      issue(FUNC_SELECT, 3'd7, 32'd0);
      issue(FUNC_MARK_DEAD, 3'd5, 32'hFFFF_FFFF);
      settle();
      write_reg(CSR_TARGET_COUNT, 32'hFFFF_FFFF);
      write_reg(CSR_HOLDOFF, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_A, 32'h0000_0001);
      write_reg(CSR_SPARE_B, 32'hA5A5_5A5A);
      issue(FUNC_SELECT, 3'd0, 32'd0);
      for (k = 0; k < MAX_TARGETS_DEF; k++) issue(FUNC_MARK_DEAD, k[IDX_W-1:0], k);
      issue(FUNC_SELECT, 3'd0, 32'hFFFF_FFFE);
      issue(FUNC_SELECT, 3'd0, 32'hFFFF_FFFF);
      settle();
      write_reg(CSR_HOLDOFF, 32'd0);
      issue(FUNC_MARK_DEAD, 3'd2, 32'd100);
      issue(FUNC_SELECT, 3'd0, 32'd99);
      issue(FUNC_SELECT, 3'd0, 32'd100);
      settle();
      write_reg(CSR_TARGET_COUNT, 32'd3);
      write_reg(CSR_HOLDOFF, 32'd10);
      issue(FUNC_MARK_DEAD, 3'd3, 32'd0);
      issue(FUNC_MARK_DEAD, 3'd0, 32'd50);
      issue(FUNC_MARK_DEAD, 3'd1, 32'd40);
      issue(FUNC_MARK_DEAD, 3'd2, 32'd55);
      issue(FUNC_SELECT, 3'd0, 32'd49);
      issue(FUNC_SELECT, 3'd0, 32'd60);
      settle();
      write_reg(CSR_TARGET_COUNT, 32'd0);
      issue(FUNC_SELECT, 3'd0, 32'd7);

      for (phase = 0; phase < 14; phase++) begin
         settle();
         r = $urandom_range(0, 9);
         if (r == 0) count = 0;
         else if (r == 1) count = $urandom_range(9, 15);
         else if (r == 2) count = MAX_TARGETS_DEF;
         else count = $urandom_range(1, MAX_TARGETS_DEF);
         listed = (count > MAX_TARGETS_DEF) ? MAX_TARGETS_DEF : count;
         write_reg(CSR_TARGET_COUNT, ($urandom() & ~32'hF) | count);
         r = $urandom_range(0, 7);
         if (r == 0) hold_ticks = '0;
         else if (r == 1) hold_ticks = '1;
         else if (r == 2) hold_ticks = $urandom();
         else hold_ticks = $urandom_range(1, 200);
         write_reg(CSR_HOLDOFF, hold_ticks);
         if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, $urandom());
         calm <= ($urandom_range(0, 3) == 0);
         tnow = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 : $urandom_range(0, 1000);
         for (k = 0; k < 64; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               now = $urandom();
            end else begin
               step = $urandom_range(0, 40);
               tnow = (tnow > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : tnow + step;
               now = tnow;
            end
            if ($urandom_range(0, 1) == 0) begin
               issue(FUNC_SELECT, IDX_W'($urandom_range(0, 7)), now);
            end else begin
               if (listed != 0 && $urandom_range(0, 7) != 0)
                  idx = IDX_W'($urandom_range(0, listed - 1));
               else
                  idx = IDX_W'($urandom_range(0, 7));
               issue(FUNC_MARK_DEAD, idx, now);
            end
         end
      end

      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ files.f @@
design/fts_pkg.sv
design/fts_front.sv
design/fts_back.sv
design/failover_target_selector.sv
design/fts_checker.sv
bench/fts_tb_pkg.sv
bench/fts_checker.sv
bench/tb_failover_target_selector.sv
